// ===== sv/tli_pkg.sv =====
// Package with the shared types and constants of the table linear interpolator.
`default_nettype none
package tli_pkg;
	localparam int MAX_KNOTS_DEF = 64;
	localparam int MIN_KNOTS = 2;
	localparam int CNT_W = 7;
	localparam int IDX_W = 6;

	localparam logic CMD_WRITE = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FEW = 2'd1;
	localparam logic [1:0] ST_SAT = 2'd2;

	localparam logic [0:0] REG_KNOT_COUNT = 1'b0;

	typedef struct packed {
		logic               cmd;
		logic [IDX_W-1:0]   knot_index;
		logic signed [31:0] knot_x;
		logic signed [31:0] knot_y;
		logic signed [31:0] query_x;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [IDX_W-1:0]   segment;
		logic [1:0]         status;
	} out_item_t;
endpackage
`default_nettype wire

// ===== sv/tli_front.sv =====
// Front part: accepts items and queues them, two entries deep.
`default_nettype none
module tli_front (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	output logic                  in_stall,
	input  wire tli_pkg::in_item_t in_item,
	output logic                  q_valid,
	input  wire logic             q_take,
	output tli_pkg::in_item_t     q_item
);
	import tli_pkg::*;

	in_item_t  buf_q [2];
	logic      wr_ptr_q, rd_ptr_q;
	logic [1:0] fill_q;
	logic      push, pop;

	assign in_stall = (fill_q == 2'd2);
	assign push = in_valid && !in_stall;
	assign pop = q_take && q_valid;
	assign q_valid = (fill_q != 2'd0);
	assign q_item = buf_q[rd_ptr_q];

	// Payload storage.
	always_ff @(posedge clk) begin
		if (push) buf_q[wr_ptr_q] <= in_item;
	end

	// Pointers and fill level.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= ~wr_ptr_q;
			if (pop) rd_ptr_q <= ~rd_ptr_q;
			fill_q <= fill_q + {1'b0, push} - {1'b0, pop};
		end
	end
endmodule
`default_nettype wire

// ===== sv/tli_div.sv =====
// Restoring divider, one quotient bit a cycle, 64 by 32 bits unsigned.
`default_nettype none
module tli_div (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire logic [63:0] dividend,
	input  wire logic [31:0] divisor,
	output logic             done,
	output logic [63:0]      quotient
);
	logic        busy_q;
	logic [5:0]  cnt_q;
	logic [63:0] quo_q;
	logic [32:0] rem_q;
	logic [31:0] dvs_q;
	logic [32:0] shifted;
	logic [33:0] diff;

	assign shifted = {rem_q[31:0], quo_q[63]};
	assign diff = {1'b0, shifted} - {2'b00, dvs_q};
	assign quotient = quo_q;

	// Iteration control.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done <= 1'b0;
			cnt_q <= '0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 6'd1;
				if (cnt_q == 6'd63) begin
					busy_q <= 1'b0;
					done <= 1'b1;
				end
			end
		end
	end

	// Shift and subtract datapath.
	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[33]) begin
				rem_q <= diff[32:0];
				quo_q <= {quo_q[62:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[62:0], 1'b0};
			end
		end
	end
endmodule
`default_nettype wire

// ===== sv/tli_back.sv =====
// Back part: knot memories, binary search, interpolation and result register.
`default_nettype none
module tli_back #(
	parameter int MAX_KNOTS = tli_pkg::MAX_KNOTS_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [tli_pkg::CNT_W-1:0]  knot_count,
	input  wire logic                       q_valid,
	output logic                            q_take,
	input  wire tli_pkg::in_item_t          q_item,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output tli_pkg::out_item_t              out_item
);
	import tli_pkg::*;

	localparam int AW = (MAX_KNOTS > 1) ? $clog2(MAX_KNOTS) : 1;
	localparam int NW = $clog2(MAX_KNOTS + 1);
	localparam int CW = (NW > CNT_W) ? NW : CNT_W;

	localparam logic [3:0] S_IDLE = 4'd0, S_RDEND = 4'd1, S_DIR = 4'd2,
		S_PROBE = 4'd3, S_CMP = 4'd4, S_RD0 = 4'd5, S_RD1 = 4'd6,
		S_MUL = 4'd7, S_DIV = 4'd8, S_SUM = 4'd9, S_OUT = 4'd10,
		S_PROD = 4'd11, S_START = 4'd12;

	logic signed [31:0] xmem [MAX_KNOTS];
	logic signed [31:0] ymem [MAX_KNOTS];
	logic [AW-1:0]      raddr;
	logic signed [31:0] xrd_q, yrd_q;

	logic [3:0]         state_q;
	logic [CW-1:0]      n_q;
	logic [AW-1:0]      lo_q, hi_q, mid_q;
	logic               asc_q;
	logic signed [31:0] q_q, x0_q, xfirst_q, y0_q;
	logic signed [32:0] dx_q, dy_q, den_q;
	logic               neg_q;
	logic [63:0]        prod_q;
	logic               div_start;
	logic               div_done;
	logic [63:0]        quot;
	logic [CW-1:0]      cnt_ext;
	logic [AW-1:0]      mid_c;
	logic [AW:0]        lohi;
	logic signed [35:0] sum;
	logic [31:0]        mag_dx, mag_dy, mag_den;

	assign cnt_ext = CW'(knot_count);
	assign q_take = q_valid && (state_q == S_IDLE) && !(out_valid && out_stall);
	assign lohi = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid_c = lohi[AW:1];

	// Knot memories: one write port, one registered read port.
	always_ff @(posedge clk) begin
		if (q_take && q_item.cmd == CMD_WRITE &&
		    int'(q_item.knot_index) < MAX_KNOTS) begin
			xmem[AW'(q_item.knot_index)] <= q_item.knot_x;
			ymem[AW'(q_item.knot_index)] <= q_item.knot_y;
		end
		xrd_q <= xmem[raddr];
		yrd_q <= ymem[raddr];
	end

	// Read address follows the sequencer state.
	always_comb begin
		unique case (state_q)
			S_IDLE:  raddr = '0;
			S_RDEND: raddr = AW'(n_q - CW'(1));
			S_PROBE: raddr = mid_c;
			S_RD1:   raddr = lo_q + AW'(1);
			default: raddr = lo_q;
		endcase
	end

	assign mag_dx = dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
	assign mag_dy = dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
	assign mag_den = den_q[32] ? 32'(-den_q) : den_q[31:0];
	assign div_start = (state_q == S_START);

	tli_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.dividend(prod_q), .divisor(mag_den), .done(div_done), .quotient(quot)
	);

	assign sum = (quot > 64'h3_FFFF_FFFF) ?
		(neg_q ? -36'sh4_0000_0000 : 36'sh4_0000_0000) :
		(36'(y0_q) + (neg_q ? -$signed({2'b00, quot[33:0]}) :
		$signed({2'b00, quot[33:0]})));

	// Result valid: raised when a result is ready, dropped when it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid <= 1'b0;
		else if (state_q == S_OUT && (!out_valid || !out_stall))
			out_valid <= 1'b1;
		else if (out_valid && !out_stall)
			out_valid <= 1'b0;
	end

	// Search and interpolation sequencer. The address read in IDLE gives knot 0.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			unique case (state_q)
				S_IDLE: if (q_take && q_item.cmd == CMD_QUERY) begin
					n_q <= (cnt_ext > CW'(MAX_KNOTS)) ? CW'(MAX_KNOTS) : cnt_ext;
					q_q <= q_item.query_x;
					if (cnt_ext < CW'(MIN_KNOTS)) begin
						out_item <= '{value: '0, segment: '0, status: ST_FEW};
						state_q <= S_OUT;
					end else
						state_q <= S_RDEND;
				end
				S_RDEND: begin
					xfirst_q <= xrd_q;
					lo_q <= '0;
					hi_q <= AW'(n_q - CW'(1));
					state_q <= S_DIR;
				end
				S_DIR: begin
					asc_q <= xrd_q >= xfirst_q;
					state_q <= S_PROBE;
				end
				S_PROBE: begin
					if ({1'b0, hi_q} - {1'b0, lo_q} > (AW+1)'(1)) begin
						mid_q <= mid_c;
						state_q <= S_CMP;
					end else begin
						if (CW'(lo_q) > n_q - CW'(MIN_KNOTS))
							lo_q <= AW'(n_q - CW'(MIN_KNOTS));
						state_q <= S_RD0;
					end
				end
				S_CMP: begin
					if ((q_q >= xrd_q) == asc_q) lo_q <= mid_q;
					else hi_q <= mid_q;
					state_q <= S_PROBE;
				end
				S_RD0: begin
					state_q <= S_RD1;
				end
				// Left knot arrives; its distance to the query is taken here.
				S_RD1: begin
					x0_q <= xrd_q;
					y0_q <= yrd_q;
					dx_q <= 33'(q_q) - 33'(xrd_q);
					state_q <= S_MUL;
				end
				// Right knot arrives; the segment differences are taken here.
				S_MUL: begin
					dy_q <= 33'(yrd_q) - 33'(y0_q);
					den_q <= 33'(xrd_q) - 33'(x0_q);
					state_q <= S_PROD;
				end
				// Product and sign, registered ahead of the division.
				S_PROD: begin
					prod_q <= 64'(mag_dx) * 64'(mag_dy);
					neg_q <= (dx_q != 0 && dy_q != 0) &&
						((dx_q[32] ^ dy_q[32]) ^ den_q[32]);
					state_q <= S_START;
				end
				S_START: begin
					state_q <= S_DIV;
				end
				S_DIV: if (div_done) state_q <= S_SUM;
				S_SUM: begin
					out_item.segment <= IDX_W'(lo_q);
					if (den_q == 33'sd0) begin
						out_item.value <= y0_q;
						out_item.status <= ST_OK;
					end else if (sum > 36'sh0_7FFF_FFFF) begin
						out_item.value <= 32'sh7FFF_FFFF;
						out_item.status <= ST_SAT;
					end else if (sum < -36'sh0_8000_0000) begin
						out_item.value <= 32'sh8000_0000;
						out_item.status <= ST_SAT;
					end else begin
						out_item.value <= sum[31:0];
						out_item.status <= ST_OK;
					end
					state_q <= S_OUT;
				end
				S_OUT: if (!out_valid || !out_stall) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

// ===== sv/table_linear_interpolator_top.sv =====
// Top level of the table linear interpolator: configuration port and the two parts.
// A knot write is stored in the back part's knot memories. A query runs a binary
// search over the knots, then reads the two segment knots and interpolates with
// the shift-subtract divider. One query is in work at a time; fewer than two
// knots gives the error result without a search. Reset clears the count and control.
`default_nettype none
module table_linear_interpolator_top #(
	parameter int MAX_KNOTS = tli_pkg::MAX_KNOTS_DEF
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire tli_pkg::in_item_t  in_item,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output tli_pkg::out_item_t      out_item,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [1:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic [31:0]             prdata,
	output logic                    pready
);
	import tli_pkg::*;

	logic [CNT_W-1:0] knot_count_q;
	logic             q_valid, q_take;
	in_item_t         q_item;

	assign pready = 1'b1;
	assign prdata = (paddr[1] == REG_KNOT_COUNT) ? 32'(knot_count_q) : '0;

	// Register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) knot_count_q <= '0;
		else if (psel && penable && pwrite && paddr[1] == REG_KNOT_COUNT)
			knot_count_q <= pwdata[CNT_W-1:0];
	end

	tli_front u_front (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.in_item(in_item), .q_valid(q_valid), .q_take(q_take), .q_item(q_item)
	);

	tli_back #(.MAX_KNOTS(MAX_KNOTS)) u_back (
		.clk(clk), .arst_n(arst_n), .knot_count(knot_count_q),
		.q_valid(q_valid), .q_take(q_take), .q_item(q_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
	);
endmodule
`default_nettype wire

// ===== sv/tli_checker.sv =====
// Port checker for the table linear interpolator, bound to the top level.
`default_nettype none
module tli_checker (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               in_valid,
	input wire logic               in_stall,
	input wire tli_pkg::in_item_t  in_item,
	input wire logic               out_valid,
	input wire logic               out_stall,
	input wire tli_pkg::out_item_t out_item
);
	import tli_pkg::*;

	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_stall |=> in_valid && $stable(in_item))
		else $error("offered item changed while stalled");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_item))
		else $error("result changed while stalled");
	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.status != 2'd3)
		else $error("unknown status");
	a_few: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_FEW |-> out_item.value == 0)
		else $error("error result carries a value");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.status == ST_SAT |->
		out_item.value == 32'sh7FFF_FFFF || out_item.value == 32'sh8000_0000)
		else $error("saturated result is not a limit");
endmodule

bind table_linear_interpolator_top tli_checker u_checker (
	.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
	.in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
	.out_item(out_item)
);
`default_nettype wire
